// File: design/debug_command_framer_assert.svh
// assertion macros used by the framer top level
// no dependencies; included by files that carry concurrent checks
`ifndef DEBUG_COMMAND_FRAMER_ASSERT_SVH
`define DEBUG_COMMAND_FRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define DCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("framer check failed: same-cycle implication");

// next-cycle implication, held off during reset
`define DCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("framer check failed: next-cycle implication");

`else

`define DCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/dcf_pkg.sv
// types and constants of the debug command framer
// no dependencies; imported by dcf_cfg_if and both framer modules
`timescale 1ns / 1ps

package dcf_pkg;

  // frame kind reported with each byte
  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_BINARY = 2'd1,
    KIND_TEXT   = 2'd2
  } frame_kind_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_OP       = 3'd0,
    CFG_WRITE_OP      = 3'd1,
    CFG_RESET_OP      = 3'd2,
    CFG_DISCONNECT_OP = 3'd3,
    CFG_HANDSHAKE_OP  = 3'd4
  } cfg_index_t;

  // opcode reset values
  localparam logic [7:0] READ_OP_RST       = 8'd1;
  localparam logic [7:0] WRITE_OP_RST      = 8'd2;
  localparam logic [7:0] RESET_OP_RST      = 8'd3;
  localparam logic [7:0] DISCONNECT_OP_RST = 8'd4;
  localparam logic [7:0] HANDSHAKE_OP_RST  = 8'd5;

  // last byte index of each binary frame, and the idle value
  localparam logic [2:0] LAST_READ      = 3'd4;
  localparam logic [2:0] LAST_WRITE     = 3'd7;
  localparam logic [2:0] LAST_SINGLE    = 3'd0;
  localparam logic [2:0] LAST_HANDSHAKE = 3'd3;
  localparam logic [2:0] LAST_IDLE      = 3'd1;

  // characters handled in a text line
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // configured opcodes
  typedef struct packed {
    logic [7:0] read_op;
    logic [7:0] write_op;
    logic [7:0] reset_op;
    logic [7:0] disconnect_op;
    logic [7:0] handshake_op;
  } dcf_opcodes_t;

  // frame state apart from the byte counter
  typedef struct packed {
    logic       is_text;
    logic [2:0] last_idx;
    logic       prev_space;
  } dcf_frame_state_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  stored_byte;
    logic [6:0]  byte_position;
    logic        frame_done;
    frame_kind_t frame_kind;
    logic [7:0]  frame_length;
  } dcf_result_t;

endpackage

// File: design/dcf_if.sv
// channel interfaces of the debug command framer: input bytes, results, config writes
// depends on dcf_pkg
`timescale 1ns / 1ps

// received byte channel
interface dcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface dcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stored_byte;
  logic [6:0] byte_position;
  logic       frame_done;
  logic [1:0] frame_kind;
  logic [7:0] frame_length;

  modport source (output valid, output stored_byte, output byte_position,
                  output frame_done, output frame_kind, output frame_length,
                  input ready);
  modport sink (input valid, input stored_byte, input byte_position,
                input frame_done, input frame_kind, input frame_length,
                output ready);
endinterface

// configuration write channel
interface dcf_cfg_if;
  import dcf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/dcf_frame_step.sv
// per-byte framing decision: kept byte, position, close and length, next state
// depends on dcf_pkg
`timescale 1ns / 1ps

module dcf_frame_step
  import dcf_pkg::*;
#(
  parameter int CNT_W    = 7,
  parameter int LAST_POS = 127
) (
  input  logic [7:0]       rx_byte,
  input  logic [CNT_W-1:0] count,
  input  dcf_frame_state_t state,
  input  dcf_opcodes_t     ops,
  output dcf_result_t      result,
  output logic [CNT_W-1:0] count_nxt,
  output dcf_frame_state_t state_nxt
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LAST_POS);

  logic       first;
  logic       is_text;
  logic [2:0] last_idx;
  logic [7:0] kept;
  logic       bin_done;
  logic       text_done;
  logic       done;
  logic [7:0] count_ext;

  assign first     = (count == '0);
  assign count_ext = 8'(count);

  // frame type from the opening byte, first match wins
  always_comb begin
    is_text  = state.is_text;
    last_idx = state.last_idx;
    if (first) begin
      is_text = 1'b0;
      priority if (rx_byte == ops.read_op) begin
        last_idx = LAST_READ;
      end else if (rx_byte == ops.write_op) begin
        last_idx = LAST_WRITE;
      end else if (rx_byte == ops.reset_op) begin
        last_idx = LAST_SINGLE;
      end else if (rx_byte == ops.disconnect_op) begin
        last_idx = LAST_SINGLE;
      end else if (rx_byte == ops.handshake_op) begin
        last_idx = LAST_HANDSHAKE;
      end else begin
        is_text  = 1'b1;
        last_idx = LAST_IDLE;
      end
    end
  end

  // close conditions
  assign bin_done  = !is_text && (count_ext >= {5'd0, last_idx});
  assign text_done = is_text && ((rx_byte == CH_LF) || (count >= LAST_CNT));
  assign done      = bin_done || text_done;

  // kept byte: cr, the line terminator and the byte that fills the line become zero
  always_comb begin
    kept = rx_byte;
    if (is_text && ((rx_byte == CH_CR) || text_done)) begin
      kept = 8'd0;
    end
  end

  // result fields
  always_comb begin
    result.stored_byte   = kept;
    result.byte_position = 7'(count);
    result.frame_done    = done;
    result.frame_kind    = KIND_OPEN;
    result.frame_length  = 8'd0;
    if (bin_done) begin
      result.frame_kind   = KIND_BINARY;
      result.frame_length = count_ext + 8'd1;
    end else if (text_done) begin
      result.frame_kind = KIND_TEXT;
      // one trailing space is dropped; an empty line stays at zero
      if (!first && state.prev_space) begin
        result.frame_length = count_ext - 8'd1;
      end else begin
        result.frame_length = count_ext;
      end
    end
  end

  // state update
  always_comb begin
    if (done) begin
      count_nxt            = '0;
      state_nxt.is_text    = 1'b0;
      state_nxt.last_idx   = LAST_IDLE;
      state_nxt.prev_space = 1'b0;
    end else begin
      count_nxt            = count + CNT_W'(1);
      state_nxt.is_text    = is_text;
      state_nxt.last_idx   = last_idx;
      state_nxt.prev_space = is_text ? (kept == CH_SPACE) : state.prev_space;
    end
  end

endmodule

// File: design/debug_command_framer.sv
// top level of the debug command framer: input register, framing step, result register
// depends on dcf_pkg, dcf_if, dcf_frame_step and debug_command_framer_assert.svh
//
//   channel    dir  payload                                           beat when
//   in_chan    in   rx_byte                                           valid & ready
//   out_chan   out  stored_byte, byte_position, frame_done,
//                   frame_kind, frame_length                          valid & ready
//   cfg_chan   in   index, data (opcode registers 0..4)               valid & ready
//
// one result beat per input beat; each byte passes the input register and then the
// result register; sustained rate one byte per cycle while out_chan is ready;
// the input register and the result register each hold one beat, so a stalled
// result still lets one more byte in
// rst_n is synchronous: counters clear and opcodes return to 1..5
// cfg_chan is always ready; writes take effect on the next cycle
`timescale 1ns / 1ps
`include "debug_command_framer_assert.svh"

module debug_command_framer
  import dcf_pkg::*;
#(
  parameter int LINE_BUFFER_DEPTH = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  dcf_in_if.sink       in_chan,
  dcf_out_if.source    out_chan,
  dcf_cfg_if.sink      cfg_chan
);

  localparam int CNT_W = $clog2(LINE_BUFFER_DEPTH);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r;
  dcf_result_t      out_res_r;
  logic [CNT_W-1:0] count_r;
  dcf_frame_state_t state_r;
  dcf_opcodes_t     ops_r;

  dcf_result_t      step_res;
  logic [CNT_W-1:0] count_nxt;
  dcf_frame_state_t state_nxt;
  logic             s1_adv;
  logic             in_beat;

  logic             out_done_beat;
  logic             out_open_beat;
  logic             out_bin_beat;
  logic             out_text_beat;
  logic             open_clean;
  logic             bin_len_ok;
  logic             step_close;
  logic             close_cleared;

  // handshakes
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // opcode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ops_r.read_op       <= READ_OP_RST;
      ops_r.write_op      <= WRITE_OP_RST;
      ops_r.reset_op      <= RESET_OP_RST;
      ops_r.disconnect_op <= DISCONNECT_OP_RST;
      ops_r.handshake_op  <= HANDSHAKE_OP_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_READ_OP:       ops_r.read_op       <= cfg_chan.data;
        CFG_WRITE_OP:      ops_r.write_op      <= cfg_chan.data;
        CFG_RESET_OP:      ops_r.reset_op      <= cfg_chan.data;
        CFG_DISCONNECT_OP: ops_r.disconnect_op <= cfg_chan.data;
        CFG_HANDSHAKE_OP:  ops_r.handshake_op  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_byte_r <= in_chan.rx_byte;
    end
  end

  // framing decision
  dcf_frame_step #(
    .CNT_W    (CNT_W),
    .LAST_POS (LINE_BUFFER_DEPTH - 1)
  ) u_step (
    .rx_byte   (s1_byte_r),
    .count     (count_r),
    .state     (state_r),
    .ops       (ops_r),
    .result    (step_res),
    .count_nxt (count_nxt),
    .state_nxt (state_nxt)
  );

  // frame state advances with each byte leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r            <= '0;
      state_r.is_text    <= 1'b0;
      state_r.last_idx   <= LAST_IDLE;
      state_r.prev_space <= 1'b0;
    end else if (s1_adv) begin
      count_r <= count_nxt;
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  // result ports
  assign out_chan.valid         = out_valid_r;
  assign out_chan.stored_byte   = out_res_r.stored_byte;
  assign out_chan.byte_position = out_res_r.byte_position;
  assign out_chan.frame_done    = out_res_r.frame_done;
  assign out_chan.frame_kind    = out_res_r.frame_kind;
  assign out_chan.frame_length  = out_res_r.frame_length;

  // terms for the checks
  assign out_done_beat = out_valid_r && out_res_r.frame_done;
  assign out_open_beat = out_valid_r && !out_res_r.frame_done;
  assign out_bin_beat  = out_valid_r && (out_res_r.frame_kind == KIND_BINARY);
  assign out_text_beat = out_valid_r && (out_res_r.frame_kind == KIND_TEXT);
  assign open_clean    = (out_res_r.frame_kind == KIND_OPEN) && (out_res_r.frame_length == 8'd0);
  assign bin_len_ok    = (out_res_r.frame_length >= 8'd1) && (out_res_r.frame_length <= 8'd8);
  assign step_close    = s1_adv && step_res.frame_done;
  assign close_cleared = (count_r == '0) && !state_r.prev_space;

  // checks
  `DCF_ASSERT_IMPLY(a_done_has_kind, clk, rst_n, out_done_beat, out_res_r.frame_kind != KIND_OPEN)
  `DCF_ASSERT_IMPLY(a_open_no_length, clk, rst_n, out_open_beat, open_clean)
  `DCF_ASSERT_IMPLY(a_binary_length, clk, rst_n, out_bin_beat, bin_len_ok)
  `DCF_ASSERT_IMPLY(a_text_end_zero, clk, rst_n, out_text_beat, out_res_r.stored_byte == 8'd0)
  `DCF_ASSERT_NEXT(a_close_clears_count, clk, rst_n, step_close, close_cleared)

endmodule
